[rtl/core/pgd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgd_pkg
// Shared types, constants and helper functions of the pheromone grid store.
// ----------------------------------------------------------------------------
package pgd_pkg;

    localparam int MAX_COLUMNS   = 64;
    localparam int MAX_ROWS      = 64;
    localparam int STRENGTH_BITS = 16;

    localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 8;

    localparam logic [STRENGTH_BITS:0] STRENGTH_MAX = {1'b0, {STRENGTH_BITS{1'b1}}};
    localparam logic [STRENGTH_BITS:0] SAT_LIMIT =
        (STRENGTH_MAX > (STRENGTH_BITS + 1)'(51200)) ? (STRENGTH_BITS + 1)'(51200)
                                                    : STRENGTH_MAX;
    localparam logic [7:0] OPACITY_FULL = 8'd255;

    localparam int DIV_W      = STRENGTH_BITS + 8;
    localparam int DVS_W      = STRENGTH_BITS + 3;
    localparam int STEP_W     = $clog2(DIV_W + 1);
    localparam int AXIS_STEPS = 15;

    localparam int PADDR_W = 5;

    typedef enum logic [1:0] {
        OP_DEPOSIT = 2'd0,
        OP_QUERY   = 2'd1,
        OP_DECAY   = 2'd2,
        OP_CLEAR   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        REG_COLUMNS  = 3'd0,
        REG_ROWS     = 3'd1,
        REG_TILE_W   = 3'd2,
        REG_TILE_H   = 3'd3,
        REG_DECAY    = 3'd4,
        REG_INITIAL  = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [6:0]  grid_columns;
        logic [6:0]  grid_rows;
        logic [11:0] tile_width;
        logic [11:0] tile_height;
        logic [15:0] decay_rate;
        logic [15:0] initial_strength;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [6:0] v,
                                                     input logic [CNT_W-1:0] maxv);
        logic [CNT_W-1:0] r;
        begin
            r = CNT_W'(v);
            if (v == 7'd0)
            begin
                r = CNT_W'(1);
            end
            else if (CNT_W'(v) > maxv)
            begin
                r = maxv;
            end
            return r;
        end
    endfunction

    function automatic logic [IDX_W-1:0] clamp_index(input logic [DIV_W-1:0] q,
                                                     input logic [CNT_W-1:0] count);
        logic [CNT_W-1:0] r;
        begin
            if (q >= DIV_W'(count))
            begin
                r = count - CNT_W'(1);
            end
            else
            begin
                r = q[CNT_W-1:0];
            end
            return r[IDX_W-1:0];
        end
    endfunction

endpackage

[rtl/core/pgd_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgd_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pgd_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  pgd_pkg::div_req_t req,
    output pgd_pkg::div_rsp_t rsp
);

    logic [pgd_pkg::DIV_W-1:0]  shreg_reg;
    logic [pgd_pkg::DVS_W-1:0]  rem_reg;
    logic [pgd_pkg::DVS_W-1:0]  divisor_reg;
    logic [pgd_pkg::STEP_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [pgd_pkg::DVS_W:0]    trial;
    logic                       fits;

    assign trial = {rem_reg, shreg_reg[pgd_pkg::DIV_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - pgd_pkg::STEP_W'(1);
                if (cnt_reg == pgd_pkg::STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            shreg_reg   <= req.dividend << (pgd_pkg::STEP_W'(pgd_pkg::DIV_W) - req.steps);
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= pgd_pkg::DVS_W'(trial - {1'b0, divisor_reg});
            end
            else
            begin
                rem_reg <= trial[pgd_pkg::DVS_W-1:0];
            end
            shreg_reg <= {shreg_reg[pgd_pkg::DIV_W-2:0], fits};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = shreg_reg;

endmodule

[rtl/core/pgd_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgd_cfg
// APB register file holding the grid geometry, the decay rate and the initial strength.
// ----------------------------------------------------------------------------
module pgd_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pgd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output pgd_pkg::cfg_t               cfg
);

    pgd_pkg::cfg_t cfg_reg;
    logic [2:0]    index;
    logic          wr_en;

    assign index  = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_columns     <= 7'd64;
            cfg_reg.grid_rows        <= 7'd64;
            cfg_reg.tile_width       <= 12'd16;
            cfg_reg.tile_height      <= 12'd16;
            cfg_reg.decay_rate       <= 16'd128;
            cfg_reg.initial_strength <= 16'd128;
        end
        else if (wr_en)
        begin
            case (index)
                pgd_pkg::REG_COLUMNS: cfg_reg.grid_columns     <= pwdata[6:0];
                pgd_pkg::REG_ROWS:    cfg_reg.grid_rows        <= pwdata[6:0];
                pgd_pkg::REG_TILE_W:  cfg_reg.tile_width       <= pwdata[11:0];
                pgd_pkg::REG_TILE_H:  cfg_reg.tile_height      <= pwdata[11:0];
                pgd_pkg::REG_DECAY:   cfg_reg.decay_rate       <= pwdata[15:0];
                pgd_pkg::REG_INITIAL: cfg_reg.initial_strength <= pwdata[15:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            pgd_pkg::REG_COLUMNS: prdata = 32'(cfg_reg.grid_columns);
            pgd_pkg::REG_ROWS:    prdata = 32'(cfg_reg.grid_rows);
            pgd_pkg::REG_TILE_W:  prdata = 32'(cfg_reg.tile_width);
            pgd_pkg::REG_TILE_H:  prdata = 32'(cfg_reg.tile_height);
            pgd_pkg::REG_DECAY:   prdata = 32'(cfg_reg.decay_rate);
            pgd_pkg::REG_INITIAL: prdata = 32'(cfg_reg.initial_strength);
            default:              prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/pheromone_grid_decay_store_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pheromone_grid_decay_store_core
// Grid of pheromone strengths with deposit, query, decay sweep and clear.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// request   in         start high, busy low      opcode, pos_x, pos_y, amount, time_step
// result    out        done strobe, one cycle    strength, opacity, tile_col, tile_row
// config    in/out     APB, pready always high   paddr, pwdata, prdata
//
// A deposit and a query wait on the shared divider, which gives one quotient bit per
// cycle for the column, the row and, for a query only, the opacity.
// A decay sweep reads and then writes each tile (states S_DK_RD, S_DK_WR), and a clear
// writes each tile in state S_CLR.
// After reset a clearing pass over every tile runs with busy high.
// The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module pheromone_grid_decay_store_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  opcode,
    input  logic signed [15:0]          pos_x,
    input  logic signed [15:0]          pos_y,
    input  logic [15:0]                 amount,
    input  logic [15:0]                 time_step,
    output logic                        done,
    output logic [15:0]                 strength,
    output logic [7:0]                  opacity,
    output logic [5:0]                  tile_col,
    output logic [5:0]                  tile_row,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pgd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_X_GO,
        S_X_WAIT,
        S_Y_GO,
        S_Y_WAIT,
        S_ADDR,
        S_READ,
        S_RDATA,
        S_O_GO,
        S_O_WAIT,
        S_DK_RD,
        S_DK_WR,
        S_CLR
    } state_t;

    localparam int SB = pgd_pkg::STRENGTH_BITS;
    localparam int AW = pgd_pkg::ADDR_W;

    pgd_pkg::cfg_t     cfg;
    pgd_pkg::div_req_t div_req;
    pgd_pkg::div_rsp_t div_rsp;

    state_t                    state_reg;
    logic [AW-1:0]             sweep_reg;
    logic [1:0]                op_reg;
    logic [14:0]               x_reg;
    logic [14:0]               y_reg;
    logic [15:0]               amount_reg;
    logic [21:0]               loss_reg;
    logic [pgd_pkg::IDX_W-1:0] col_reg;
    logic [pgd_pkg::IDX_W-1:0] row_reg;
    logic [AW-1:0]             addr_reg;
    logic [SB-1:0]             str_reg;
    logic                      done_reg;
    logic [15:0]               strength_reg;
    logic [7:0]                opacity_reg;
    logic [5:0]                tile_col_reg;
    logic [5:0]                tile_row_reg;

    logic [SB-1:0]             grid_mem [pgd_pkg::CELL_COUNT];
    logic [SB-1:0]             mem_rdata_reg;
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [AW-1:0]             mem_raddr;
    logic [SB-1:0]             mem_wdata;

    logic [pgd_pkg::CNT_W-1:0] cols;
    logic [pgd_pkg::CNT_W-1:0] rows;
    logic [11:0]               tile_w;
    logic [11:0]               tile_h;
    logic [15:0]               init_eff;
    logic [pgd_pkg::DVS_W-1:0] init5;
    logic [SB:0]               dep_sum;
    logic [SB-1:0]             dep_value;
    logic [SB-1:0]             decay_value;
    logic [13:0]               tile_index;
    logic                      accept;
    logic                      sweep_last;

    pgd_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pgd_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cols     = pgd_pkg::clamp_count(cfg.grid_columns,
                                           pgd_pkg::CNT_W'(pgd_pkg::MAX_COLUMNS));
    assign rows     = pgd_pkg::clamp_count(cfg.grid_rows,
                                           pgd_pkg::CNT_W'(pgd_pkg::MAX_ROWS));
    assign tile_w   = (cfg.tile_width == 12'd0) ? 12'd1 : cfg.tile_width;
    assign tile_h   = (cfg.tile_height == 12'd0) ? 12'd1 : cfg.tile_height;
    assign init_eff = (cfg.initial_strength == 16'd0) ? 16'd1 : cfg.initial_strength;
    assign init5    = pgd_pkg::DVS_W'({init_eff, 2'b00}) + pgd_pkg::DVS_W'(init_eff);

    assign tile_index = 14'(col_reg) + 14'(row_reg) * 14'(cols);

    assign dep_sum   = {1'b0, mem_rdata_reg} + (SB + 1)'(amount_reg);
    assign dep_value = (dep_sum >= pgd_pkg::SAT_LIMIT) ? pgd_pkg::SAT_LIMIT[SB-1:0]
                                                       : dep_sum[SB-1:0];
    assign decay_value = (22'(mem_rdata_reg) <= loss_reg) ? '0
                                                          : SB'(22'(mem_rdata_reg) - loss_reg);

    assign busy       = (state_reg != S_IDLE);
    assign accept     = start && !busy;
    assign sweep_last = (sweep_reg == AW'(pgd_pkg::CELL_COUNT - 1));

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        div_req.steps    = pgd_pkg::STEP_W'(pgd_pkg::AXIS_STEPS);
        case (state_reg)
            S_X_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = pgd_pkg::DIV_W'(x_reg);
                div_req.divisor  = pgd_pkg::DVS_W'(tile_w);
            end
            S_Y_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = pgd_pkg::DIV_W'(y_reg);
                div_req.divisor  = pgd_pkg::DVS_W'(tile_h);
            end
            S_O_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {str_reg, 8'd0} - pgd_pkg::DIV_W'(str_reg);
                div_req.divisor  = init5;
                div_req.steps    = pgd_pkg::STEP_W'(pgd_pkg::DIV_W);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = sweep_reg;
        mem_wdata = '0;
        mem_raddr = (state_reg == S_DK_RD) ? sweep_reg : addr_reg;
        case (state_reg)
            S_INIT, S_CLR:
            begin
                mem_we = 1'b1;
            end
            S_DK_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = decay_value;
            end
            S_RDATA:
            begin
                mem_we    = (op_reg == pgd_pkg::OP_DEPOSIT);
                mem_waddr = addr_reg;
                mem_wdata = dep_value;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= grid_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            sweep_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_INIT:
                begin
                    sweep_reg <= sweep_reg + AW'(1);
                    if (sweep_last)
                    begin
                        sweep_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg     <= opcode;
                        x_reg      <= pos_x[15] ? 15'd0 : pos_x[14:0];
                        y_reg      <= pos_y[15] ? 15'd0 : pos_y[14:0];
                        amount_reg <= amount;
                        loss_reg   <= 22'((32'(cfg.decay_rate) * 32'(time_step)) >> 10);
                        sweep_reg  <= '0;
                        case (opcode)
                            pgd_pkg::OP_DEPOSIT, pgd_pkg::OP_QUERY: state_reg <= S_X_GO;
                            pgd_pkg::OP_DECAY:                      state_reg <= S_DK_RD;
                            default:                                state_reg <= S_CLR;
                        endcase
                    end
                end
                S_X_GO:
                begin
                    state_reg <= S_X_WAIT;
                end
                S_X_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        col_reg   <= pgd_pkg::clamp_index(div_rsp.quotient, cols);
                        state_reg <= S_Y_GO;
                    end
                end
                S_Y_GO:
                begin
                    state_reg <= S_Y_WAIT;
                end
                S_Y_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        row_reg   <= pgd_pkg::clamp_index(div_rsp.quotient, rows);
                        state_reg <= S_ADDR;
                    end
                end
                S_ADDR:
                begin
                    addr_reg  <= tile_index[AW-1:0];
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    state_reg <= S_RDATA;
                end
                S_RDATA:
                begin
                    str_reg <= mem_rdata_reg;
                    if (op_reg == pgd_pkg::OP_DEPOSIT)
                    begin
                        done_reg     <= 1'b1;
                        strength_reg <= '0;
                        opacity_reg  <= '0;
                        tile_col_reg <= 6'(col_reg);
                        tile_row_reg <= 6'(row_reg);
                        state_reg    <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_O_GO;
                    end
                end
                S_O_GO:
                begin
                    state_reg <= S_O_WAIT;
                end
                S_O_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        done_reg     <= 1'b1;
                        strength_reg <= 16'(str_reg);
                        if (div_rsp.quotient > pgd_pkg::DIV_W'(pgd_pkg::OPACITY_FULL))
                        begin
                            opacity_reg <= pgd_pkg::OPACITY_FULL;
                        end
                        else
                        begin
                            opacity_reg <= div_rsp.quotient[7:0];
                        end
                        tile_col_reg <= 6'(col_reg);
                        tile_row_reg <= 6'(row_reg);
                        state_reg    <= S_IDLE;
                    end
                end
                S_DK_RD:
                begin
                    state_reg <= S_DK_WR;
                end
                S_DK_WR, S_CLR:
                begin
                    sweep_reg <= sweep_reg + AW'(1);
                    if (state_reg == S_DK_WR)
                    begin
                        state_reg <= S_DK_RD;
                    end
                    if (sweep_last)
                    begin
                        sweep_reg    <= '0;
                        done_reg     <= 1'b1;
                        strength_reg <= '0;
                        opacity_reg  <= '0;
                        tile_col_reg <= '0;
                        tile_row_reg <= '0;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign strength = strength_reg;
    assign opacity  = opacity_reg;
    assign tile_col = tile_col_reg;
    assign tile_row = tile_row_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("Result strobe raised outside the idle state.");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("Result strobe held for more than one cycle.");

    a_init_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_INIT) |=> (state_reg != S_INIT))
        else $error("Clearing pass entered again after reset.");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_X_WAIT || state_reg == S_Y_WAIT ||
                          state_reg == S_O_WAIT))
        else $error("Divider finished while no request was waiting for it.");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("Divider started while still busy.");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == S_RDATA) |-> ((SB + 1)'(mem_wdata) <= pgd_pkg::SAT_LIMIT))
        else $error("Deposit wrote a strength above the saturation limit.");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pheromone grid store: a directed table of
// deposits, queries, sweeps and clears, then random requests under several
// register settings, each result checked against the table or a grid model.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_DECAYS = 40;
    localparam int MAX_CLEARS = 25;

    typedef struct packed {
        logic [15:0] strength;
        logic [7:0]  opacity;
        logic [5:0]  tile_col;
        logic [5:0]  tile_row;
    } tile_report_t;

    typedef struct packed {
        pgd_pkg::opcode_t op;
        logic [15:0]      x;
        logic [15:0]      y;
        logic [15:0]      amount;
        logic [15:0]      step;
        logic             typed;
        tile_report_t     want;
    } stim_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    pgd_pkg::opcode_t             opcode = pgd_pkg::OP_DEPOSIT;
    logic signed [15:0]           pos_x = '0;
    logic signed [15:0]           pos_y = '0;
    logic [15:0]                  amount = '0;
    logic [15:0]                  time_step = '0;
    logic                         done;
    logic [15:0]                  strength;
    logic [7:0]                   opacity;
    logic [5:0]                   tile_col;
    logic [5:0]                   tile_row;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [pgd_pkg::PADDR_W-1:0]  paddr = '0;
    logic [31:0]                  pwdata = '0;
    logic [31:0]                  prdata;
    logic                         pready;

    logic [15:0]                  strength_model [0:pgd_pkg::CELL_COUNT-1];
    pgd_pkg::cfg_t                cfg_model;
    tile_report_t                 expected_reports [$];
    tile_report_t                 oldest_report;
    stim_row_t                    directed_rows [$];
    logic [15:0]                  last_x = '0;
    logic [15:0]                  last_y = '0;

    int failures = 0;
    int n_deposit = 0;
    int n_saturated = 0;
    int n_query = 0;
    int n_query_hits = 0;
    int n_decay = 0;
    int n_clear = 0;
    int n_settings = 0;

    pheromone_grid_decay_store_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .amount    (amount),
        .time_step (time_step),
        .done      (done),
        .strength  (strength),
        .opacity   (opacity),
        .tile_col  (tile_col),
        .tile_row  (tile_row),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    function automatic int unsigned usable_count(input logic [6:0] v, input int unsigned maxv);
        int unsigned r;
        r = v;
        if (v == 7'd0)
        begin
            r = 1;
        end
        else if (r > maxv)
        begin
            r = maxv;
        end
        return r;
    endfunction

    function automatic int unsigned axis_tile(input logic [15:0] raw, input logic [11:0] size,
                                              input int unsigned count);
        int unsigned v;
        int unsigned s;
        int unsigned t;
        v = raw[15] ? 0 : raw;
        s = (size == 12'd0) ? 1 : size;
        t = v / s;
        if (t >= count)
        begin
            t = count - 1;
        end
        return t;
    endfunction

    function automatic tile_report_t apply_request(input pgd_pkg::opcode_t op,
                                                   input logic [15:0] x,
                                                   input logic [15:0] y, input logic [15:0] amt,
                                                   input logic [15:0] step);
        tile_report_t    rep;
        int unsigned     cols;
        int unsigned     rows;
        int unsigned     col;
        int unsigned     row;
        int unsigned     tile_index;
        longint unsigned init;
        longint unsigned sum;
        longint unsigned loss;
        longint unsigned q;
        rep = '0;
        cols = usable_count(cfg_model.grid_columns, pgd_pkg::MAX_COLUMNS);
        rows = usable_count(cfg_model.grid_rows, pgd_pkg::MAX_ROWS);
        case (op)
            pgd_pkg::OP_DEPOSIT, pgd_pkg::OP_QUERY:
            begin
                col = axis_tile(x, cfg_model.tile_width, cols);
                row = axis_tile(y, cfg_model.tile_height, rows);
                tile_index = col + row * cols;
                if (tile_index >= pgd_pkg::CELL_COUNT)
                begin
                    tile_index = pgd_pkg::CELL_COUNT - 1;
                end
                rep.tile_col = 6'(col);
                rep.tile_row = 6'(row);
                if (op == pgd_pkg::OP_DEPOSIT)
                begin
                    n_deposit++;
                    sum = 64'(strength_model[tile_index]) + 64'(amt);
                    if (sum >= 64'(pgd_pkg::SAT_LIMIT))
                    begin
                        sum = 64'(pgd_pkg::SAT_LIMIT);
                        n_saturated++;
                    end
                    strength_model[tile_index] = 16'(sum);
                end
                else
                begin
                    n_query++;
                    init = (cfg_model.initial_strength == 16'd0) ? 1 : cfg_model.initial_strength;
                    q = (64'(strength_model[tile_index]) * 64'(pgd_pkg::OPACITY_FULL))
                        / (init * 5);
                    rep.strength = strength_model[tile_index];
                    rep.opacity = (q > 64'(pgd_pkg::OPACITY_FULL)) ? pgd_pkg::OPACITY_FULL
                                                                   : 8'(q);
                    if (strength_model[tile_index] != 16'd0)
                    begin
                        n_query_hits++;
                    end
                end
            end
            pgd_pkg::OP_DECAY:
            begin
                n_decay++;
                loss = (64'(cfg_model.decay_rate) * 64'(step)) >> 10;
                for (int i = 0; i < pgd_pkg::CELL_COUNT; i++)
                begin
                    if (64'(strength_model[i]) <= loss)
                    begin
                        strength_model[i] = '0;
                    end
                    else
                    begin
                        strength_model[i] = strength_model[i] - 16'(loss);
                    end
                end
            end
            default:
            begin
                n_clear++;
                for (int i = 0; i < pgd_pkg::CELL_COUNT; i++)
                begin
                    strength_model[i] = '0;
                end
            end
        endcase
        return rep;
    endfunction

    function automatic logic [31:0] reg_value(input pgd_pkg::cfg_t c,
                                              input pgd_pkg::reg_index_t idx);
        logic [31:0] v;
        case (idx)
            pgd_pkg::REG_COLUMNS: v = 32'(c.grid_columns);
            pgd_pkg::REG_ROWS:    v = 32'(c.grid_rows);
            pgd_pkg::REG_TILE_W:  v = 32'(c.tile_width);
            pgd_pkg::REG_TILE_H:  v = 32'(c.tile_height);
            pgd_pkg::REG_DECAY:   v = 32'(c.decay_rate);
            default:              v = 32'(c.initial_strength);
        endcase
        return v;
    endfunction

    function automatic pgd_pkg::cfg_t random_config();
        pgd_pkg::cfg_t c;
        c.grid_columns = 7'($urandom_range(1, 64));
        c.grid_rows = 7'($urandom_range(1, 64));
        c.tile_width = 12'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 4095)
                                                       : $urandom_range(1, 64));
        c.tile_height = 12'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 4095)
                                                        : $urandom_range(1, 64));
        c.decay_rate = 16'($urandom_range(0, 65535));
        c.initial_strength = 16'($urandom_range(1, 51200));
        return c;
    endfunction

    function automatic stim_row_t make_row(input pgd_pkg::opcode_t op, input int x, input int y,
                                           input int amt, input int step, input bit typed,
                                           input int s, input int o, input int c, input int r);
        stim_row_t row;
        row.op = op;
        row.x = 16'(x);
        row.y = 16'(y);
        row.amount = 16'(amt);
        row.step = 16'(step);
        row.typed = typed;
        row.want.strength = 16'(s);
        row.want.opacity = 8'(o);
        row.want.tile_col = 6'(c);
        row.want.tile_row = 6'(r);
        return row;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            failures++;
        end
    endtask

    task automatic wait_quiet();
        while (expected_reports.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input pgd_pkg::reg_index_t idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= pgd_pkg::PADDR_W'(4 * int'(idx));
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
    endtask

    task automatic load_config(input pgd_pkg::cfg_t c);
        pgd_pkg::reg_index_t idx;
        logic [31:0]         rd;
        wait_quiet();
        for (int k = 0; k < 6; k++)
        begin
            idx = pgd_pkg::reg_index_t'(k);
            apb_access(1'b1, idx, reg_value(c, idx), rd);
        end
        cfg_model = c;
        for (int k = 0; k < 6; k++)
        begin
            idx = pgd_pkg::reg_index_t'(k);
            apb_access(1'b0, idx, '0, rd);
            check_field(idx.name(), reg_value(c, idx), rd);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        n_settings++;
        @(posedge clk);
    endtask

    task automatic send_request(input pgd_pkg::opcode_t op, input logic [15:0] x,
                                input logic [15:0] y,
                                input logic [15:0] amt, input logic [15:0] step,
                                input logic typed, input tile_report_t want, input bit idle);
        tile_report_t rep;
        start <= 1'b1;
        opcode <= op;
        pos_x <= x;
        pos_y <= y;
        amount <= amt;
        time_step <= step;
        do
            @(posedge clk);
        while (busy);
        rep = apply_request(op, x, y, amt, step);
        if (typed)
        begin
            rep = want;
        end
        expected_reports.push_back(rep);
        if (idle && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            if ($urandom_range(0, 1) == 1)
            begin
                do
                    @(posedge clk);
                while (busy);
            end
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic run_random(input int count, input bit idle);
        pgd_pkg::opcode_t op;
        logic [15:0]      x;
        logic [15:0]      y;
        logic [15:0]      amt;
        logic [15:0]      step;
        int               pick;
        int               span_x;
        int               span_y;
        tile_report_t     none;
        none = '0;
        span_x = ((cfg_model.tile_width == 12'd0) ? 1 : cfg_model.tile_width)
                 * (usable_count(cfg_model.grid_columns, pgd_pkg::MAX_COLUMNS) + 1);
        span_y = ((cfg_model.tile_height == 12'd0) ? 1 : cfg_model.tile_height)
                 * (usable_count(cfg_model.grid_rows, pgd_pkg::MAX_ROWS) + 1);
        if (span_x > 32767)
        begin
            span_x = 32767;
        end
        if (span_y > 32767)
        begin
            span_y = 32767;
        end
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 46)
            begin
                op = pgd_pkg::OP_DEPOSIT;
            end
            else if (pick < 92)
            begin
                op = pgd_pkg::OP_QUERY;
            end
            else if (pick < 97 && n_decay < MAX_DECAYS)
            begin
                op = pgd_pkg::OP_DECAY;
            end
            else if (pick >= 97 && n_clear < MAX_CLEARS)
            begin
                op = pgd_pkg::OP_CLEAR;
            end
            else
            begin
                op = pgd_pkg::OP_QUERY;
            end
            x = 16'($urandom_range(0, span_x));
            y = 16'($urandom_range(0, span_y));
            if ($urandom_range(0, 4) == 0)
            begin
                x = 16'($urandom);
            end
            if ($urandom_range(0, 4) == 0)
            begin
                y = 16'($urandom);
            end
            if (op == pgd_pkg::OP_QUERY && $urandom_range(0, 1) == 1)
            begin
                x = last_x;
                y = last_y;
            end
            amt = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 255))
                                              : 16'($urandom_range(0, 51200));
            step = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 63)) : 16'($urandom);
            if (op == pgd_pkg::OP_DEPOSIT)
            begin
                last_x = x;
                last_y = y;
            end
            send_request(op, x, y, amt, step, 1'b0, none, idle && ((n / 20) % 3 != 2));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got strength %0d opacity %0d %s",
                         $time, strength, opacity,
                         $sformatf("tile %0d,%0d", tile_col, tile_row));
                failures++;
            end
            else
            begin
                oldest_report = expected_reports.pop_front();
                check_field("strength", oldest_report.strength, strength);
                check_field("opacity", oldest_report.opacity, opacity);
                check_field("tile_col", oldest_report.tile_col, tile_col);
                check_field("tile_row", oldest_report.tile_row, tile_row);
            end
        end
    end

    initial
    begin
        #100000000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < pgd_pkg::CELL_COUNT; i++)
        begin
            strength_model[i] = '0;
        end
        cfg_model = {7'd64, 7'd64, 12'd16, 12'd16, 16'd128, 16'd128};

        directed_rows.push_back(make_row(pgd_pkg::OP_QUERY, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        directed_rows.push_back(make_row(pgd_pkg::OP_DEPOSIT, -32768, -1, 51200, 0, 1,
                                         0, 0, 0, 0));
        directed_rows.push_back(make_row(pgd_pkg::OP_QUERY, -5, -5, 0, 0, 1, 51200, 255, 0, 0));
        directed_rows.push_back(make_row(pgd_pkg::OP_DEPOSIT, 0, 0, 1, 0, 1, 0, 0, 0, 0));
        directed_rows.push_back(make_row(pgd_pkg::OP_QUERY, 15, 15, 0, 0, 1, 51200, 255, 0, 0));
        directed_rows.push_back(make_row(pgd_pkg::OP_DEPOSIT, 32767, 32767, 640, 0, 1,
                                         0, 0, 63, 63));
        directed_rows.push_back(make_row(pgd_pkg::OP_QUERY, 32767, 32767, 0, 0, 1,
                                         640, 255, 63, 63));
        directed_rows.push_back(make_row(pgd_pkg::OP_DEPOSIT, 1023, 0, 128, 0, 1, 0, 0, 63, 0));
        directed_rows.push_back(make_row(pgd_pkg::OP_QUERY, 1008, 15, 0, 0, 1, 128, 51, 63, 0));
        directed_rows.push_back(make_row(pgd_pkg::OP_DEPOSIT, 16, 17, 3, 0, 1, 0, 0, 1, 1));
        directed_rows.push_back(make_row(pgd_pkg::OP_QUERY, 31, 31, 0, 0, 1, 3, 1, 1, 1));
        directed_rows.push_back(make_row(pgd_pkg::OP_DECAY, 500, 500, 0, 1024, 1, 0, 0, 0, 0));
        directed_rows.push_back(make_row(pgd_pkg::OP_QUERY, 0, 0, 0, 0, 1, 51072, 255, 0, 0));
        directed_rows.push_back(make_row(pgd_pkg::OP_QUERY, 32767, 32767, 0, 0, 1,
                                         512, 204, 63, 63));
        directed_rows.push_back(make_row(pgd_pkg::OP_QUERY, 1008, 0, 0, 0, 1, 0, 0, 63, 0));
        directed_rows.push_back(make_row(pgd_pkg::OP_QUERY, 16, 16, 0, 0, 1, 0, 0, 1, 1));
        directed_rows.push_back(make_row(pgd_pkg::OP_DECAY, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        directed_rows.push_back(make_row(pgd_pkg::OP_DECAY, 0, 0, 0, 65535, 1, 0, 0, 0, 0));
        directed_rows.push_back(make_row(pgd_pkg::OP_QUERY, 0, 0, 0, 0, 1, 42881, 255, 0, 0));
        directed_rows.push_back(make_row(pgd_pkg::OP_DEPOSIT, 100, 200, 12345, 0, 0,
                                         0, 0, 0, 0));
        directed_rows.push_back(make_row(pgd_pkg::OP_QUERY, 100, 200, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(pgd_pkg::OP_CLEAR, -1, -1, 51200, 65535, 1,
                                         0, 0, 0, 0));
        directed_rows.push_back(make_row(pgd_pkg::OP_QUERY, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        directed_rows.push_back(make_row(pgd_pkg::OP_QUERY, 100, 200, 0, 0, 1, 0, 0, 6, 12));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
                         directed_rows[i].amount, directed_rows[i].step,
                         directed_rows[i].typed, directed_rows[i].want, 1'b1);
        end
        start <= 1'b0;

        load_config({7'd1, 7'd1, 12'd1, 12'd1, 16'd0, 16'd1});
        run_random(110, 1'b1);
        start <= 1'b0;
        load_config({7'd64, 7'd64, 12'd4095, 12'd4095, 16'd65535, 16'd51200});
        run_random(110, 1'b1);
        start <= 1'b0;
        load_config({7'd0, 7'd127, 12'd0, 12'd0, 16'd1, 16'd0});
        run_random(110, 1'b1);
        start <= 1'b0;
        load_config({7'd7, 7'd13, 12'd37, 12'd5, 16'd300, 16'd200});
        run_random(110, 1'b1);
        start <= 1'b0;
        load_config(random_config());
        run_random(110, 1'b1);
        start <= 1'b0;
        load_config(random_config());
        run_random(110, 1'b1);
        start <= 1'b0;
        load_config(random_config());
        run_random(70, 1'b0);
        start <= 1'b0;

        wait_quiet();
        repeat (200) @(posedge clk);

        $display("Covered %0d deposits (%0d saturating), %0d queries (%0d nonzero),",
                 n_deposit, n_saturated, n_query, n_query_hits);
        $display("%0d decay sweeps and %0d clears over %0d register settings.",
                 n_decay, n_clear, n_settings + 1);
        if (failures == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
